### hw/rtl/ddmr_pkg.sv
package ddmr_pkg;

	localparam int DIGITS_DEF = 8;
	localparam int VALUE_W    = 27;
	localparam int ROW_W      = 3;
	localparam int PIXEL_W    = 40;
	localparam int GLYPH_W    = 5;
	localparam int ROWS       = 5;
	localparam int DIGIT_W    = 4;
	localparam int BASE       = 10;

	// divide by ten: q = (v * RECIP10) >> RECIP_SHIFT, exact for v below 2^32
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          PROD_W      = VALUE_W + 32;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	// 5x5 font, leftmost pixel in the high bit
	localparam logic [GLYPH_W-1:0] GLYPHS [ROWS][BASE] = '{
		'{5'h1F, 5'h01, 5'h1F, 5'h1F, 5'h11, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F},
		'{5'h11, 5'h01, 5'h01, 5'h01, 5'h11, 5'h10, 5'h10, 5'h11, 5'h11, 5'h11},
		'{5'h11, 5'h01, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h01, 5'h1F, 5'h1F},
		'{5'h11, 5'h01, 5'h10, 5'h01, 5'h01, 5'h01, 5'h11, 5'h01, 5'h11, 5'h01},
		'{5'h1F, 5'h01, 5'h1F, 5'h1F, 5'h01, 5'h1F, 5'h1F, 5'h01, 5'h1F, 5'h1F}
	};

	function automatic logic [GLYPH_W-1:0] glyph(input logic [ROW_W-1:0] r,
	                                             input logic [DIGIT_W-1:0] d);
		logic [GLYPH_W-1:0] g;
		g = '0;
		if (int'(r) < ROWS && int'(d) < BASE) begin
			g = GLYPHS[int'(r)][int'(d)];
		end
		return g;
	endfunction

endpackage

### hw/rtl/ddmr_digit_stage.sv
module ddmr_digit_stage #(
	parameter int DIGITS = ddmr_pkg::DIGITS_DEF,
	parameter int IDX    = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_in,
	input  logic [ddmr_pkg::VALUE_W-1:0]           value_in,
	input  logic [DIGITS*ddmr_pkg::DIGIT_W-1:0]    digits_in,
	output logic                                   stall_out,
	output logic                                   valid_out,
	output logic [ddmr_pkg::VALUE_W-1:0]           value_out,
	output logic [DIGITS*ddmr_pkg::DIGIT_W-1:0]    digits_out,
	input  logic                                   stall_in
);

	logic [ddmr_pkg::PROD_W-1:0]                prod;
	logic [ddmr_pkg::VALUE_W-1:0]               quot;
	logic [ddmr_pkg::VALUE_W-1:0]               rem_full;
	logic [DIGITS*ddmr_pkg::DIGIT_W-1:0]        digits_nx;
	logic                                       valid_s1;
	logic [ddmr_pkg::VALUE_W-1:0]               value_s1;
	logic [DIGITS*ddmr_pkg::DIGIT_W-1:0]        digits_s1;

	// quotient by reciprocal, remainder by shift and add
	always_comb begin
		prod      = ddmr_pkg::PROD_W'(value_in) * ddmr_pkg::PROD_W'(ddmr_pkg::RECIP10);
		quot      = ddmr_pkg::VALUE_W'(prod >> ddmr_pkg::RECIP_SHIFT);
		rem_full  = value_in - ((quot << 3) + (quot << 1));
		digits_nx = digits_in;
		digits_nx[IDX*ddmr_pkg::DIGIT_W +: ddmr_pkg::DIGIT_W] = rem_full[ddmr_pkg::DIGIT_W-1:0];
	end

	assign stall_out = valid_s1 && stall_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_out) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_out && valid_in) begin
			value_s1  <= quot;
			digits_s1 <= digits_nx;
		end
	end

	assign valid_out  = valid_s1;
	assign value_out  = value_s1;
	assign digits_out = digits_s1;

endmodule

### hw/rtl/ddmr_row_gen.sv
module ddmr_row_gen #(
	parameter int DIGITS = ddmr_pkg::DIGITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_in,
	input  logic [DIGITS*ddmr_pkg::DIGIT_W-1:0]  digits_in,
	output logic                                 stall_out,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ddmr_pkg::ROW_W-1:0]           row,
	output logic [ddmr_pkg::PIXEL_W-1:0]         pixels,
	output logic                                 last
);

	logic [DIGITS*ddmr_pkg::DIGIT_W-1:0] digits_q;
	logic [DIGITS-1:0]                   shown_q;
	logic [DIGITS-1:0]                   shown_nx;
	logic [ddmr_pkg::ROW_W-1:0]          row_q;
	logic                                busy_q;
	logic                                out_valid_q;
	logic [ddmr_pkg::ROW_W-1:0]          row_s1;
	logic [ddmr_pkg::PIXEL_W-1:0]        pixels_s1;
	logic                                last_s1;
	logic [ddmr_pkg::PIXEL_W-1:0]        px;
	logic                                advance;
	logic                                final_row;
	logic                                take;
	logic                                seen;

	// leading zero blanking
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (digits_in[i*ddmr_pkg::DIGIT_W +: ddmr_pkg::DIGIT_W] != '0) begin
				seen = 1'b1;
			end
			shown_nx[i] = seen;
		end
	end

	// one font row across all digits, most significant digit ends up highest
	always_comb begin
		px = '0;
		for (int i = 0; i < DIGITS; i++) begin
			px = {px[ddmr_pkg::PIXEL_W-ddmr_pkg::GLYPH_W-1:0],
			      shown_q[i] ? ddmr_pkg::glyph(row_q,
			          digits_q[i*ddmr_pkg::DIGIT_W +: ddmr_pkg::DIGIT_W])
			                 : ddmr_pkg::GLYPH_W'(0)};
		end
	end

	assign advance   = !out_valid_q || !out_stall;
	assign final_row = row_q == ddmr_pkg::LAST_ROW;
	assign stall_out = busy_q && !(advance && final_row);
	assign take      = valid_in && !stall_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (take) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (busy_q && advance) begin
				if (final_row) begin
					busy_q <= 1'b0;
				end
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			digits_q <= digits_in;
			shown_q  <= shown_nx;
		end
		if (busy_q && advance) begin
			row_s1    <= row_q;
			pixels_s1 <= px;
			last_s1   <= final_row;
		end
	end

	assign out_valid = out_valid_q;
	assign row       = row_s1;
	assign pixels    = pixels_s1;
	assign last      = last_s1;

endmodule

### hw/rtl/decimal_dot_matrix_renderer.sv
// a value beat passes DIGITS digit-stage registers, then the row generator's digit
//   and output registers; each value gives five row beats back to back, one row per
//   cycle unless out_stall holds it; the next value goes in as the last row leaves
// reset: arst_n clears all stage valid bits, the row counter and the output valid;
//   the block takes a beat in the first cycle after reset
module decimal_dot_matrix_renderer #(
	parameter int DIGITS = ddmr_pkg::DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// value beats in
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ddmr_pkg::VALUE_W-1:0]  value,
	// row beats out
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ddmr_pkg::ROW_W-1:0]    row,
	output logic [ddmr_pkg::PIXEL_W-1:0]  pixels,
	output logic                          last
);

	localparam int DW = DIGITS * ddmr_pkg::DIGIT_W;

	// link j feeds digit stage j; link DIGITS feeds the row generator
	logic                         valid_l  [DIGITS+1];
	logic                         stall_l  [DIGITS+1];
	logic [ddmr_pkg::VALUE_W-1:0] value_l  [DIGITS+1];
	logic [DW-1:0]                digits_l [DIGITS+1];

	assign valid_l[0]  = in_valid;
	assign value_l[0]  = value;
	assign digits_l[0] = '0;
	assign in_stall    = stall_l[0];

	// one divide by ten per stage, least significant digit first; whatever is
	// left above the top digit is dropped, so the value shows modulo 10^DIGITS
	for (genvar j = 0; j < DIGITS; j++) begin : g_digit
		ddmr_digit_stage #(
			.DIGITS (DIGITS),
			.IDX    (DIGITS - 1 - j)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid_in   (valid_l[j]),
			.value_in   (value_l[j]),
			.digits_in  (digits_l[j]),
			.stall_out  (stall_l[j]),
			.valid_out  (valid_l[j+1]),
			.value_out  (value_l[j+1]),
			.digits_out (digits_l[j+1]),
			.stall_in   (stall_l[j+1])
		);
	end

	// blanking, font lookup and the output register; the remaining quotient
	// at the end of the chain carries nothing that is shown
	ddmr_row_gen #(
		.DIGITS (DIGITS)
	) u_row_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_l[DIGITS] && (value_l[DIGITS] == value_l[DIGITS] )),
		.digits_in (digits_l[DIGITS]),
		.stall_out (stall_l[DIGITS]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row       (row),
		.pixels    (pixels),
		.last      (last)
	);

endmodule
